>>> hw/rtl/sv39ptm_pkg.sv
package sv39ptm_pkg;

    // defaults for the top-level parameters
    localparam int MAX_TABLES_DEF    = 16;
    localparam int MAX_RUN_PAGES_DEF = 4096;

    // field widths
    localparam int VPN_W    = 27;
    localparam int PPN_W    = 44;
    localparam int COUNT_W  = 13;
    localparam int PERM_W   = 10;
    localparam int TPAGE_W  = 4;
    localparam int SLOT_W   = 9;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 64;
    localparam int TUSE_W   = 5;
    localparam int CFG_W    = 64;
    localparam int PADDR_W  = 4;

    // page table entry layout
    localparam int PTE_PPN_SHIFT = 10;
    localparam int PTE_PAD_W     = ENTRY_W - PPN_W - PTE_PPN_SHIFT;
    localparam int SLOTS_PER_TABLE = 512;

    // operation codes
    localparam logic OP_MAP  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd2;

    // register index, taken from paddr bit 3
    localparam logic REG_POOL_BASE = 1'b0;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  entry_value;
        logic [COUNT_W-1:0]  pages_mapped;
        logic [TUSE_W-1:0]   tables_in_use;
    } t_result;

endpackage

>>> hw/rtl/sv39ptm_ram.sv
module sv39ptm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/sv39ptm_walker.sv
module sv39ptm_walker #(
    parameter int MAX_TABLES    = sv39ptm_pkg::MAX_TABLES_DEF,
    parameter int MAX_RUN_PAGES = sv39ptm_pkg::MAX_RUN_PAGES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // pool base from the register file
    input  logic [sv39ptm_pkg::PPN_W-1:0]         i_pool_base,
    // item channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_operation,
    input  logic [sv39ptm_pkg::VPN_W-1:0]         i_virt_page_number,
    input  logic [sv39ptm_pkg::PPN_W-1:0]         i_phys_page_number,
    input  logic [sv39ptm_pkg::COUNT_W-1:0]       i_page_count,
    input  logic [sv39ptm_pkg::PERM_W-1:0]        i_permission_bits,
    input  logic [sv39ptm_pkg::TPAGE_W-1:0]       i_table_page,
    input  logic [sv39ptm_pkg::SLOT_W-1:0]        i_entry_slot,
    // result toward the output register
    output logic                                  o_res_valid,
    input  logic                                  i_res_take,
    output sv39ptm_pkg::t_result                  o_res,
    // page store port
    output logic                                  o_mem_we,
    output logic [$clog2(MAX_TABLES*512)-1:0]     o_mem_waddr,
    output logic [sv39ptm_pkg::ENTRY_W-1:0]       o_mem_wdata,
    output logic [$clog2(MAX_TABLES*512)-1:0]     o_mem_raddr,
    input  logic [sv39ptm_pkg::ENTRY_W-1:0]       i_mem_rdata
);

    localparam int TW     = $clog2(MAX_TABLES);
    localparam int AW     = $clog2(MAX_TABLES + 1);
    localparam int DEPTH  = MAX_TABLES * sv39ptm_pkg::SLOTS_PER_TABLE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SW     = sv39ptm_pkg::SLOT_W;
    localparam int PPN_W  = sv39ptm_pkg::PPN_W;
    localparam int CNT_W  = sv39ptm_pkg::COUNT_W;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_ISSUE = 8'b0000_0100,
        S_RDATA = 8'b0000_1000,
        S_L2    = 8'b0001_0000,
        S_L1    = 8'b0010_0000,
        S_LEAF  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [AW-1:0] r_alloc, n_alloc;
    logic r_op, n_op;
    logic [sv39ptm_pkg::VPN_W-1:0] r_vpn, n_vpn;
    logic [PPN_W-1:0] r_ppn, n_ppn;
    logic [CNT_W-1:0] r_remain, n_remain;
    logic [sv39ptm_pkg::PERM_W-1:0] r_perm, n_perm;
    logic [TW-1:0] r_tp, n_tp;
    logic tp_bad, r_tp_bad, n_tp_bad;
    logic [SW-1:0] r_slot, n_slot;
    logic [TW-1:0] r_table, n_table;
    logic [sv39ptm_pkg::STATUS_W-1:0] r_status, n_status;
    logic [sv39ptm_pkg::ENTRY_W-1:0] r_entry, n_entry;
    logic [CNT_W-1:0] r_done, n_done;

    // vpn fields of the current page
    logic [SW-1:0] vpn2, vpn1, vpn0;
    // shared descend logic on the entry just read
    logic            ent_valid;
    logic [PPN_W-1:0] ent_off;
    logic            ent_in_pool;
    logic            pool_full;
    logic [TW-1:0]   fresh;
    logic [TW-1:0]   next_table;
    logic [sv39ptm_pkg::ENTRY_W-1:0] ptr_entry;
    logic [sv39ptm_pkg::ENTRY_W-1:0] leaf_entry;
    logic [CNT_W-1:0] clamped;

    assign vpn2 = r_vpn[3*SW-1:2*SW];
    assign vpn1 = r_vpn[2*SW-1:SW];
    assign vpn0 = r_vpn[SW-1:0];

    assign ent_valid   = i_mem_rdata[0];
    assign ent_off     = i_mem_rdata[sv39ptm_pkg::PTE_PPN_SHIFT +: PPN_W] - i_pool_base;
    assign ent_in_pool = ent_off < PPN_W'(r_alloc);
    assign pool_full   = (r_alloc == AW'(MAX_TABLES));
    assign fresh       = TW'(r_alloc);
    assign next_table  = ent_valid ? ent_off[TW-1:0] : fresh;
    assign ptr_entry   = {{sv39ptm_pkg::PTE_PAD_W{1'b0}}, i_pool_base + PPN_W'(r_alloc),
                          {(sv39ptm_pkg::PTE_PPN_SHIFT-1){1'b0}}, 1'b1};
    assign leaf_entry  = {{sv39ptm_pkg::PTE_PAD_W{1'b0}}, r_ppn,
                          r_perm | sv39ptm_pkg::PERM_W'(1)};

    assign tp_bad  = (32'(i_table_page) >= MAX_TABLES);
    assign clamped = (32'(i_page_count) > MAX_RUN_PAGES) ? CNT_W'(MAX_RUN_PAGES)
                                                         : i_page_count;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_FIN);
    assign o_res.status        = r_status;
    assign o_res.entry_value   = r_entry;
    assign o_res.pages_mapped  = r_done;
    assign o_res.tables_in_use = sv39ptm_pkg::TUSE_W'(r_alloc);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_alloc    = r_alloc;
        n_op       = r_op;
        n_vpn      = r_vpn;
        n_ppn      = r_ppn;
        n_remain   = r_remain;
        n_perm     = r_perm;
        n_tp       = r_tp;
        n_tp_bad   = r_tp_bad;
        n_slot     = r_slot;
        n_table    = r_table;
        n_status   = r_status;
        n_entry    = r_entry;
        n_done     = r_done;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_clr_addr;
        o_mem_wdata = '0;
        o_mem_raddr = {TW'(0), vpn2};

        unique case (r_state)
            S_CLEAR: begin
                o_mem_we   = 1'b1;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_operation;
                    n_vpn    = i_virt_page_number;
                    n_ppn    = i_phys_page_number;
                    n_remain = clamped;
                    n_perm   = i_permission_bits;
                    n_tp     = TW'(i_table_page);
                    n_tp_bad = tp_bad;
                    n_slot   = i_entry_slot;
                    n_status = sv39ptm_pkg::ST_OK;
                    n_entry  = '0;
                    n_done   = '0;
                    n_state  = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (r_op == sv39ptm_pkg::OP_READ) begin
                    o_mem_raddr = {r_tp, r_slot};
                    if (r_tp_bad) begin
                        n_status = sv39ptm_pkg::ST_OUTSIDE;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_RDATA;
                    end
                end else if (r_remain == '0) begin
                    n_state = S_FIN;
                end else begin
                    // root entry for this page
                    o_mem_raddr = {TW'(0), vpn2};
                    n_state     = S_L2;
                end
            end
            S_RDATA: begin
                n_entry = i_mem_rdata;
                n_state = S_FIN;
            end
            S_L2: begin
                o_mem_raddr = {next_table, vpn1};
                if (ent_valid && !ent_in_pool) begin
                    n_status = sv39ptm_pkg::ST_OUTSIDE;
                    n_state  = S_FIN;
                end else if (!ent_valid && pool_full) begin
                    n_status = sv39ptm_pkg::ST_EXHAUSTED;
                    n_state  = S_FIN;
                end else begin
                    if (!ent_valid) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = {TW'(0), vpn2};
                        o_mem_wdata = ptr_entry;
                        n_alloc     = r_alloc + AW'(1);
                    end
                    n_table = next_table;
                    n_state = S_L1;
                end
            end
            S_L1: begin
                if (ent_valid && !ent_in_pool) begin
                    n_status = sv39ptm_pkg::ST_OUTSIDE;
                    n_state  = S_FIN;
                end else if (!ent_valid && pool_full) begin
                    n_status = sv39ptm_pkg::ST_EXHAUSTED;
                    n_state  = S_FIN;
                end else begin
                    if (!ent_valid) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = {r_table, vpn1};
                        o_mem_wdata = ptr_entry;
                        n_alloc     = r_alloc + AW'(1);
                    end
                    n_table = next_table;
                    n_state = S_LEAF;
                end
            end
            S_LEAF: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = {r_table, vpn0};
                o_mem_wdata = leaf_entry;
                n_entry     = leaf_entry;
                n_done      = r_done + CNT_W'(1);
                n_remain    = r_remain - CNT_W'(1);
                n_vpn       = r_vpn + sv39ptm_pkg::VPN_W'(1);
                n_ppn       = r_ppn + PPN_W'(1);
                n_state     = S_ISSUE;
            end
            S_FIN: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_alloc    <= AW'(1);
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_alloc    <= n_alloc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_vpn    <= n_vpn;
        r_ppn    <= n_ppn;
        r_remain <= n_remain;
        r_perm   <= n_perm;
        r_tp     <= n_tp;
        r_tp_bad <= n_tp_bad;
        r_slot   <= n_slot;
        r_table  <= n_table;
        r_status <= n_status;
        r_entry  <= n_entry;
        r_done   <= n_done;
    end

endmodule

>>> hw/rtl/sv39_page_table_mapper.sv
// one item at a time; a read item reads at most one page store entry, a map item walks each page
// in turn: root read, middle read, check of the middle entry, leaf write, all through the single
// page store port pair
// reset: synchronous, active low; after reset a clearing pass zeroes the page store,
// all MAX_TABLES*512 entries (8192 at the default), one entry a cycle, items stalled meanwhile
module sv39_page_table_mapper #(
    parameter int MAX_TABLES    = sv39ptm_pkg::MAX_TABLES_DEF,
    parameter int MAX_RUN_PAGES = sv39ptm_pkg::MAX_RUN_PAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sv39ptm_pkg::PADDR_W-1:0]     paddr,
    input  logic [sv39ptm_pkg::CFG_W-1:0]       pwdata,
    output logic [sv39ptm_pkg::CFG_W-1:0]       prdata,
    output logic                                pready,
    // input word channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_operation,
    input  logic [sv39ptm_pkg::VPN_W-1:0]       i_virt_page_number,
    input  logic [sv39ptm_pkg::PPN_W-1:0]       i_phys_page_number,
    input  logic [sv39ptm_pkg::COUNT_W-1:0]     i_page_count,
    input  logic [sv39ptm_pkg::PERM_W-1:0]      i_permission_bits,
    input  logic [sv39ptm_pkg::TPAGE_W-1:0]     i_table_page,
    input  logic [sv39ptm_pkg::SLOT_W-1:0]      i_entry_slot,
    // result word channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sv39ptm_pkg::STATUS_W-1:0]    o_status,
    output logic [sv39ptm_pkg::ENTRY_W-1:0]     o_entry_value,
    output logic [sv39ptm_pkg::COUNT_W-1:0]     o_pages_mapped,
    output logic [sv39ptm_pkg::TUSE_W-1:0]      o_tables_in_use
);

    localparam int DEPTH  = MAX_TABLES * sv39ptm_pkg::SLOTS_PER_TABLE;
    localparam int ADDR_W = $clog2(DEPTH);

    // pool base register
    logic [sv39ptm_pkg::PPN_W-1:0] r_pool_base;
    logic                          cfg_wr;

    // walker to page store
    logic                             mem_we;
    logic [ADDR_W-1:0]                mem_waddr;
    logic [sv39ptm_pkg::ENTRY_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]                mem_raddr;
    logic [sv39ptm_pkg::ENTRY_W-1:0]  mem_rdata;

    // walker result and the output register in front of the consumer
    logic                 res_valid;
    logic                 res_take;
    sv39ptm_pkg::t_result res;
    logic                 r_out_valid;
    sv39ptm_pkg::t_result r_out;

    // register writes land on the access phase; bit 3 of paddr selects the 8-byte register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[3] == sv39ptm_pkg::REG_POOL_BASE);
    assign prdata = (paddr[3] == sv39ptm_pkg::REG_POOL_BASE)
                    ? sv39ptm_pkg::CFG_W'(r_pool_base) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= '0;
        end else if (cfg_wr) begin
            r_pool_base <= pwdata[sv39ptm_pkg::PPN_W-1:0];
        end
    end

    // walk sequencer: clearing pass, item decode, entry reads, three-level descend, leaf write
    sv39ptm_walker #(
        .MAX_TABLES    (MAX_TABLES),
        .MAX_RUN_PAGES (MAX_RUN_PAGES)
    ) u_walker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_pool_base        (r_pool_base),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_virt_page_number (i_virt_page_number),
        .i_phys_page_number (i_phys_page_number),
        .i_page_count       (i_page_count),
        .i_permission_bits  (i_permission_bits),
        .i_table_page       (i_table_page),
        .i_entry_slot       (i_entry_slot),
        .o_res_valid        (res_valid),
        .i_res_take         (res_take),
        .o_res              (res),
        .o_mem_we           (mem_we),
        .o_mem_waddr        (mem_waddr),
        .o_mem_wdata        (mem_wdata),
        .o_mem_raddr        (mem_raddr),
        .i_mem_rdata        (mem_rdata)
    );

    // page store: all table pages, one write and one registered read a cycle
    sv39ptm_ram #(
        .WIDTH (sv39ptm_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_page_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register: the walker parks its word here once the slot is free or draining,
    // so the next item can be accepted while this word waits
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_entry_value   = r_out.entry_value;
    assign o_pages_mapped  = r_out.pages_mapped;
    assign o_tables_in_use = r_out.tables_in_use;

endmodule

>>> tb/sv/sv39_map_board_pkg.sv
package sv39_map_board_pkg;
    import sv39ptm_pkg::*;

    localparam int ALL_SLOTS  = MAX_TABLES_DEF * SLOTS_PER_TABLE;
    localparam int REPORT_CAP = 20;

    typedef struct packed {
        logic                op;
        logic [VPN_W-1:0]    vpn;
        logic [PPN_W-1:0]    ppn;
        logic [COUNT_W-1:0]  count;
        logic [PERM_W-1:0]   perm;
        logic [TPAGE_W-1:0]  tpage;
        logic [SLOT_W-1:0]   slot;
    } t_map_word;

    class page_table_board;
        logic [ENTRY_W-1:0]         store [ALL_SLOTS];
        int unsigned                allocated;
        logic [PPN_W-1:0]           base_ppn;
        t_result                    expected_words [$];
        logic [VPN_W-SLOT_W-1:0]    mapped_regions [$];
        int unsigned                errors;

        function new();
            foreach (store[k]) store[k] = '0;
            allocated = 1;
            base_ppn  = '0;
            errors    = 0;
        endfunction

        function void set_pool_base(logic [PPN_W-1:0] value);
            base_ppn = value;
        endfunction

        // follow the pointer at one slot, or hang a fresh table there
        function logic [STATUS_W-1:0] descend(int unsigned tbl, logic [SLOT_W-1:0] idx,
                                              output int unsigned child);
            int unsigned      at;
            logic [PPN_W-1:0] ptr_ppn;
            logic [PPN_W-1:0] offset;
            at    = tbl * SLOTS_PER_TABLE + idx;
            child = 0;
            if (!store[at][0]) begin
                if (allocated >= MAX_TABLES_DEF) return ST_EXHAUSTED;
                ptr_ppn   = base_ppn + PPN_W'(allocated);
                store[at] = {{PTE_PAD_W{1'b0}}, ptr_ppn, {(PTE_PPN_SHIFT-1){1'b0}}, 1'b1};
                child     = allocated;
                allocated++;
                return ST_OK;
            end
            offset = store[at][PTE_PPN_SHIFT +: PPN_W] - base_ppn;
            if (offset >= PPN_W'(allocated)) return ST_OUTSIDE;
            child = int'(offset);
            return ST_OK;
        endfunction

        function void note_item(t_map_word w);
            t_result          r;
            int unsigned      pages;
            int unsigned      mid;
            int unsigned      leaf;
            logic [VPN_W-1:0] va;
            logic [PPN_W-1:0] pa;
            logic             known;
            r = '0;
            if (w.op == OP_READ) begin
                if (w.tpage < MAX_TABLES_DEF)
                    r.entry_value = store[w.tpage * SLOTS_PER_TABLE + w.slot];
                else
                    r.status = ST_OUTSIDE;
            end else begin
                pages = (w.count > MAX_RUN_PAGES_DEF) ? MAX_RUN_PAGES_DEF : w.count;
                va = w.vpn;
                pa = w.ppn;
                for (int unsigned n = 0; n < pages; n++) begin
                    r.status = descend(0, va[2*SLOT_W +: SLOT_W], mid);
                    if (r.status != ST_OK) break;
                    r.status = descend(mid, va[SLOT_W +: SLOT_W], leaf);
                    if (r.status != ST_OK) break;
                    r.entry_value = {{PTE_PAD_W{1'b0}}, pa, w.perm};
                    r.entry_value[0] = 1'b1;
                    store[leaf * SLOTS_PER_TABLE + va[0 +: SLOT_W]] = r.entry_value;
                    r.pages_mapped++;
                    va++;
                    pa++;
                end
                // keep the 2 MiB region where each run that took pages starts, so later runs land in them
                if (r.pages_mapped != 0) begin
                    known = 1'b0;
                    foreach (mapped_regions[k])
                        if (mapped_regions[k] == w.vpn[VPN_W-1:SLOT_W]) known = 1'b1;
                    if (!known) mapped_regions.push_back(w.vpn[VPN_W-1:SLOT_W]);
                end
            end
            r.tables_in_use = TUSE_W'(allocated);
            expected_words.push_back(r);
        endfunction

        function void complain(string what, logic [ENTRY_W-1:0] want, logic [ENTRY_W-1:0] got);
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        endfunction

        function void check_word(t_result seen);
            t_result want;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: word with nothing expected, expected none, got %h",
                             $time, seen);
                return;
            end
            want = expected_words.pop_front();
            if (seen.status != want.status)
                complain("status", want.status, seen.status);
            if (seen.entry_value != want.entry_value)
                complain("entry_value", want.entry_value, seen.entry_value);
            if (seen.pages_mapped != want.pages_mapped)
                complain("pages_mapped", want.pages_mapped, seen.pages_mapped);
            if (seen.tables_in_use != want.tables_in_use)
                complain("tables_in_use", want.tables_in_use, seen.tables_in_use);
        endfunction
    endclass

endpackage

>>> tb/sv/tb_sv39_page_table_mapper.sv
module tb_sv39_page_table_mapper;
    timeunit 1ns;
    timeprecision 1ps;

    import sv39ptm_pkg::*;
    import sv39_map_board_pkg::*;

    localparam logic [PPN_W-1:0] PPN_TOP = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [CFG_W-1:0]      pwdata;
    logic [CFG_W-1:0]      prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_operation;
    logic [VPN_W-1:0]      i_virt_page_number;
    logic [PPN_W-1:0]      i_phys_page_number;
    logic [COUNT_W-1:0]    i_page_count;
    logic [PERM_W-1:0]     i_permission_bits;
    logic [TPAGE_W-1:0]    i_table_page;
    logic [SLOT_W-1:0]     i_entry_slot;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [STATUS_W-1:0]   o_status;
    logic [ENTRY_W-1:0]    o_entry_value;
    logic [COUNT_W-1:0]    o_pages_mapped;
    logic [TUSE_W-1:0]     o_tables_in_use;

    page_table_board board;

    // idling odds in percent, per word for the sender, and for the receiver
    int unsigned gap_odds   = 20;
    int unsigned stall_odds = 20;
    logic        quiet_tail = 1'b0;

    // timeout budget grows with the work handed to the block; covers the clearing pass
    longint unsigned cycle_count   = 0;
    longint unsigned budget_cycles = 100000;

    sv39_page_table_mapper DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_virt_page_number (i_virt_page_number),
        .i_phys_page_number (i_phys_page_number),
        .i_page_count       (i_page_count),
        .i_permission_bits  (i_permission_bits),
        .i_table_page       (i_table_page),
        .i_entry_slot       (i_entry_slot),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_entry_value      (o_entry_value),
        .o_pages_mapped     (o_pages_mapped),
        .o_tables_in_use    (o_tables_in_use)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > budget_cycles) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: compare every accepted word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_word({o_status, o_entry_value, o_pages_mapped, o_tables_in_use});
    end

    // receiver stalls in bursts, changed on the falling edge
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_odds != 0 && $urandom_range(0, 99) < stall_odds) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    function automatic logic [PPN_W-1:0] any_ppn();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[PPN_W-1:0];
    endfunction

    // map word; the read-only fields carry noise
    function automatic t_map_word map_word(logic [VPN_W-1:0] vpn, logic [PPN_W-1:0] ppn,
                                           logic [COUNT_W-1:0] count, logic [PERM_W-1:0] perm);
        t_map_word w;
        w.op    = OP_MAP;
        w.vpn   = vpn;
        w.ppn   = ppn;
        w.count = count;
        w.perm  = perm;
        w.tpage = TPAGE_W'($urandom);
        w.slot  = SLOT_W'($urandom);
        return w;
    endfunction

    // read word; the map fields carry noise
    function automatic t_map_word read_word(logic [TPAGE_W-1:0] tpage, logic [SLOT_W-1:0] slot);
        t_map_word w;
        w       = map_word(VPN_W'($urandom), any_ppn(), COUNT_W'($urandom), PERM_W'($urandom));
        w.op    = OP_READ;
        w.tpage = tpage;
        w.slot  = slot;
        return w;
    endfunction

    function automatic t_map_word random_word();
        t_map_word   w;
        int unsigned pick;
        if ($urandom_range(0, 3) == 0) begin
            // half the reads aim at table pages that are already allocated
            if ($urandom_range(0, 1) == 0)
                return read_word(TPAGE_W'($urandom_range(0, board.allocated - 1)),
                                 SLOT_W'($urandom));
            return read_word(TPAGE_W'($urandom), SLOT_W'($urandom));
        end
        w = map_word(VPN_W'($urandom), any_ppn(), '0, PERM_W'($urandom));
        // most runs land in regions that already hold pages, the rest is anywhere
        if (board.mapped_regions.size() != 0 && $urandom_range(0, 99) < 80)
            w.vpn[VPN_W-1:SLOT_W] =
                board.mapped_regions[$urandom_range(0, board.mapped_regions.size() - 1)];
        pick = $urandom_range(0, 999);
        if (pick < 10)
            w.count = '0;
        else if (pick < 500)
            w.count = COUNT_W'($urandom_range(1, 4));
        else if (pick < 850)
            w.count = COUNT_W'($urandom_range(5, 32));
        else if (pick < 980)
            w.count = COUNT_W'($urandom_range(33, 256));
        else if (pick < 997)
            w.count = COUNT_W'($urandom_range(257, 1024));
        else
            w.count = COUNT_W'($urandom_range(MAX_RUN_PAGES_DEF + 1, 8191));
        // now and then a run that wraps the physical page number
        if ($urandom_range(0, 49) == 0)
            w.ppn = PPN_TOP - PPN_W'($urandom_range(0, 7));
        return w;
    endfunction

    // offer one word, called on a falling edge, returns on the falling edge after acceptance
    task automatic put_word(input t_map_word w);
        if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_operation        = w.op;
        i_virt_page_number = w.vpn;
        i_phys_page_number = w.ppn;
        i_page_count       = w.count;
        i_permission_bits  = w.perm;
        i_table_page       = w.tpage;
        i_entry_slot       = w.slot;
        i_in_valid         = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        board.note_item(w);
        budget_cycles += 4 * (4 * ((w.count > MAX_RUN_PAGES_DEF) ? MAX_RUN_PAGES_DEF : w.count)
                              + 16);
        @(negedge i_clk);
    endtask

    // pool base write, only once every result is back and the block has settled
    task automatic write_pool_base(input logic [PPN_W-1:0] value);
        i_in_valid = 1'b0;
        while (board.expected_words.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(REG_POOL_BASE) << 3;
        pwdata  = CFG_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_pool_base(value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic run_random(input int unsigned items);
        for (int unsigned k = 0; k < items; k++) begin
            // idling changes every 64 words; each kind is off in a third of the stretches
            if (!quiet_tail && k % 64 == 0) begin
                gap_odds   = 20 * $urandom_range(0, 2);
                stall_odds = 20 * $urandom_range(0, 2);
            end
            put_word(random_word());
        end
    endtask

    initial begin
        t_map_word directed [$];
        board = new();
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        i_in_valid         = 1'b0;
        i_operation        = OP_MAP;
        i_virt_page_number = '0;
        i_phys_page_number = '0;
        i_page_count       = '0;
        i_permission_bits  = '0;
        i_table_page       = '0;
        i_entry_slot       = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // pool base at the very top, so table pointers wrap around the ppn space
        write_pool_base(PPN_TOP);

        // first page at the bottom: middle and leaf tables come up
        directed.push_back(map_word('0, '0, COUNT_W'(1), '0));
        // top page of the space, both page numbers wrap to zero on the second page
        directed.push_back(map_word('1, PPN_TOP, COUNT_W'(2), '1));
        // empty run
        directed.push_back(map_word(VPN_W'(5), any_ppn(), COUNT_W'(0), PERM_W'($urandom)));
        // longest count field, cut to the largest run; fills seven new leaf tables
        directed.push_back(map_word('0, 44'h1_2345_6789, '1, 10'h0CF));
        // new middle slot under an existing root entry
        directed.push_back(map_word({9'd0, 9'd100, 9'd0}, any_ppn(), COUNT_W'(3),
                                    PERM_W'($urandom)));
        // new root slot, takes the last two free tables but one
        directed.push_back(map_word({9'd5, 9'd0, 9'd7}, any_ppn(), COUNT_W'(1),
                                    PERM_W'($urandom)));
        // pool runs dry between levels: the middle pointer stays behind
        directed.push_back(map_word({9'd6, 9'd3, 9'd0}, any_ppn(), COUNT_W'(1),
                                    PERM_W'($urandom)));
        // part of a run maps, then the pool is exhausted at the next region
        directed.push_back(map_word({9'd0, 9'd7, 9'd256}, any_ppn(), COUNT_W'(4096),
                                    PERM_W'($urandom)));
        // exhausted right at the root
        directed.push_back(map_word({9'd9, 9'd1, 9'd1}, any_ppn(), COUNT_W'(5),
                                    PERM_W'($urandom)));
        // full run over tables that all exist
        directed.push_back(map_word('0, any_ppn(), COUNT_W'(4096), 10'h2AA));
        // reads: root entries, the stray middle pointer, far corners, leaf entries
        directed.push_back(read_word('0, '0));
        directed.push_back(read_word('0, SLOT_W'(6)));
        directed.push_back(read_word('0, '1));
        directed.push_back(read_word('1, '1));
        directed.push_back(read_word(TPAGE_W'(2), '0));
        directed.push_back(read_word(TPAGE_W'(4), '1));
        directed.push_back(read_word(TPAGE_W'(15), SLOT_W'(0)));
        foreach (directed[k]) put_word(directed[k]);

        run_random(350);

        // base moved up by one, wrapping to zero: every old pointer now names its neighbor table
        write_pool_base('0);
        run_random(100);

        // arbitrary base: old pointers fall outside the pool
        write_pool_base(any_ppn());
        run_random(100);

        // back to the original base
        write_pool_base(PPN_TOP);
        run_random(280);

        // closing stretch at full rate
        quiet_tail = 1'b1;
        gap_odds   = 0;
        stall_odds = 0;
        run_random(120);
        i_in_valid = 1'b0;

        while (board.expected_words.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/sv39ptm_pkg.sv
hw/rtl/sv39ptm_ram.sv
hw/rtl/sv39ptm_walker.sv
hw/rtl/sv39_page_table_mapper.sv
tb/sv/sv39_map_board_pkg.sv
tb/sv/tb_sv39_page_table_mapper.sv
